@@ hdl/sli_pkg.sv @@
// ---------------------------------------------------------------------------
// sli_pkg: shared definitions for the sorted list store
// Sizes, status and request codes, and the command broadcast to the cells.
// ---------------------------------------------------------------------------
package sli_pkg;

   localparam int DEPTH = 16;
   localparam int VAL_W = 32;
   localparam int OCC_W = 5;
   localparam int CNT_W = $clog2(DEPTH + 1);

   typedef enum logic {
      OP_INSERT = 1'b0,
      OP_DELETE = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_NOT_FOUND = 2'd1,
      STATUS_FULL      = 2'd2
   } status_type;

   typedef struct packed {
      logic             insert_en;
      logic             delete_en;
      logic [VAL_W-1:0] value;
   } cell_cmd_type;

endpackage

@@ hdl/sli_req_if.sv @@
// ---------------------------------------------------------------------------
// sli_req_if: request channel
// Valid/ready channel carrying one insert or delete request.
// ---------------------------------------------------------------------------
interface sli_req_if;
   import sli_pkg::*;

   logic             valid;
   logic             ready;
   op_type           req_type;
   logic [VAL_W-1:0] value;

   modport source (output valid, output req_type, output value, input ready);
   modport sink (input valid, input req_type, input value, output ready);

endinterface

@@ hdl/sli_rsp_if.sv @@
// ---------------------------------------------------------------------------
// sli_rsp_if: response channel
// Valid/ready channel carrying status, occupancy and the head of the list.
// ---------------------------------------------------------------------------
interface sli_rsp_if;
   import sli_pkg::*;

   logic             valid;
   logic             ready;
   status_type       status;
   logic [OCC_W-1:0] occupancy;
   logic [VAL_W-1:0] head_value;
   logic             head_valid;

   modport source (output valid, output status, output occupancy,
                   output head_value, output head_valid, input ready);
   modport sink (input valid, input status, input occupancy,
                 input head_value, input head_valid, output ready);

endinterface

@@ hdl/sli_cell.sv @@
// ---------------------------------------------------------------------------
// sli_cell: one compare-and-shift cell of the sorted chain
// Holds one entry; on insert takes the left neighbor or the new value, on
// delete takes the right neighbor, for every place at or above the value.
// ---------------------------------------------------------------------------
module sli_cell (
   input  logic                       clock,
   input  sli_pkg::cell_cmd_type      cmd,
   input  logic                       occupied,
   input  logic                       left_take,
   input  logic [sli_pkg::VAL_W-1:0]  left_entry,
   input  logic [sli_pkg::VAL_W-1:0]  right_entry,
   output logic                       take,
   output logic                       hit,
   output logic [sli_pkg::VAL_W-1:0]  entry,
   output logic [sli_pkg::VAL_W-1:0]  entry_nxt
);
   import sli_pkg::*;

   logic [VAL_W-1:0] entry_ff;
   logic [VAL_W-1:0] entry_in;
   logic             ge;

   always_comb begin
      ge   = $signed(entry_ff) >= $signed(cmd.value);
      take = !occupied || ge;
      hit  = occupied && (entry_ff == cmd.value) && !left_take;
      entry_in = entry_ff;
      if (cmd.insert_en && take) begin
         entry_in = left_take ? left_entry : cmd.value;
      end else if (cmd.delete_en && take) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry     = entry_ff;
   assign entry_nxt = entry_in;

endmodule

@@ hdl/sorted_list_insert_delete.sv @@
// ---------------------------------------------------------------------------
// sorted_list_insert_delete: sorted store with insert and delete
// A chain of compare-and-shift cells keeps the entries in ascending order.
//
//   channel  dir  fields                                     handshake
//   req      in   req_type, value                            valid/ready
//   rsp      out  status, occupancy, head_value, head_valid  valid/ready
//
// One request per cycle unless the response stalls; every cell compares and
// shifts in the same cycle; the registered response is valid the next cycle.
// Reset clears the entry count and the response valid; cell contents stay.
// A request is taken while the response register is empty or being drained,
// so a stalled response holds off new requests until it is taken.
// ---------------------------------------------------------------------------
module sorted_list_insert_delete (
   input logic     clock,
   input logic     reset,
   sli_req_if.sink   req_chan,
   sli_rsp_if.source rsp_chan
);
   import sli_pkg::*;

   cell_cmd_type     cmd;
   logic [DEPTH-1:0] take;
   logic [DEPTH-1:0] hit;
   logic [VAL_W-1:0] entry     [DEPTH];
   logic [VAL_W-1:0] entry_nxt [DEPTH];

   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   status_type       status_ff, status_in;
   logic [OCC_W-1:0] occ_ff, occ_in;
   logic [VAL_W-1:0] head_value_ff, head_value_in;
   logic             head_valid_ff, head_valid_in;

   logic accept;
   logic full;
   logic found;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept = req_chan.valid && req_chan.ready;
   assign full   = (count_ff == CNT_W'(DEPTH));
   assign found  = |hit;

   assign cmd.value     = req_chan.value;
   assign cmd.insert_en = accept && (req_chan.req_type == OP_INSERT) && !full;
   assign cmd.delete_en = accept && (req_chan.req_type == OP_DELETE) && found;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic             occupied;
      logic             left_take;
      logic [VAL_W-1:0] left_entry;
      logic [VAL_W-1:0] right_entry;

      assign occupied = CNT_W'(i) < count_ff;

      if (i == 0) begin : g_first
         assign left_take  = 1'b0;
         assign left_entry = entry[i];
      end else begin : g_mid
         assign left_take  = take[i-1];
         assign left_entry = entry[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_entry = entry[i];
      end else begin : g_inner
         assign right_entry = entry[i+1];
      end

      sli_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occupied    (occupied),
         .left_take   (left_take),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .take        (take[i]),
         .hit         (hit[i]),
         .entry       (entry[i]),
         .entry_nxt   (entry_nxt[i])
      );
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.insert_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (cmd.delete_en) begin
         count_in = count_ff - CNT_W'(1);
      end

      status_in = STATUS_DONE;
      if (req_chan.req_type == OP_INSERT) begin
         if (full) begin
            status_in = STATUS_FULL;
         end
      end else if (!found) begin
         status_in = STATUS_NOT_FOUND;
      end

      occ_in        = OCC_W'(count_in);
      head_valid_in = (count_in != '0);
      head_value_in = head_valid_in ? entry_nxt[0] : '0;

      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff     <= status_in;
         occ_ff        <= occ_in;
         head_value_ff <= head_value_in;
         head_valid_ff <= head_valid_in;
      end
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = status_ff;
   assign rsp_chan.occupancy  = occ_ff;
   assign rsp_chan.head_value = head_value_ff;
   assign rsp_chan.head_valid = head_valid_ff;

endmodule

@@ hdl/sli_checker.sv @@
// ---------------------------------------------------------------------------
// sli_checker: port-level checks for the sorted list store
// Watches the request and response channels, bound to the top level.
// ---------------------------------------------------------------------------
module sli_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [1:0]                rsp_status,
   input logic [sli_pkg::OCC_W-1:0] rsp_occupancy,
   input logic [sli_pkg::VAL_W-1:0] rsp_head_value,
   input logic                      rsp_head_valid
);
   import sli_pkg::*;

   a_rsp_follows_req : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("request accepted without a response");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_occupancy) && $stable(rsp_head_value))
      else $error("stalled response changed");

   a_empty_head : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_head_valid |-> rsp_head_value == '0 && rsp_occupancy == '0)
      else $error("empty store reports a head value");

   a_full_occ : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |-> rsp_occupancy == OCC_W'(DEPTH)
         && rsp_head_valid)
      else $error("full status with wrong occupancy");

endmodule

bind sorted_list_insert_delete sli_checker u_sli_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_status     (rsp_chan.status),
   .rsp_occupancy  (rsp_chan.occupancy),
   .rsp_head_value (rsp_chan.head_value),
   .rsp_head_valid (rsp_chan.head_valid)
);

@@ dv/sorted_list_insert_delete_tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_list_insert_delete_tb: testbench for the sorted list store
// Walks a short list of directed requests (empty store, extreme values,
// duplicates, full store), then about two thousand random requests that
// fill and drain the store in turns. Each response is checked field by
// field against a behavioral store copy or a directed entry's fields.
// ---------------------------------------------------------------------------
module sorted_list_insert_delete_tb;
   import sli_pkg::*;

   typedef struct {
      op_type           kind;
      logic [VAL_W-1:0] value;
      logic             typed;
      status_type       status;
      logic [OCC_W-1:0] occupancy;
      logic [VAL_W-1:0] head_value;
      logic             head_valid;
   } list_request_type;

   typedef struct {
      status_type       status;
      logic [OCC_W-1:0] occupancy;
      logic [VAL_W-1:0] head_value;
      logic             head_valid;
   } list_status_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sli_req_if req_chan ();
   sli_rsp_if rsp_chan ();

   sorted_list_insert_delete u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #5 clock = ~clock;

   logic signed [VAL_W-1:0] stored_values[$];
   list_status_type         expected_status[$];
   list_request_type        directed_requests[$];
   int                      accepted_total = 0;
   int                      mismatches = 0;
   logic                    req_idle_on = 1'b1;
   logic                    quiet_tail = 1'b0;
   logic                    long_hold_done = 1'b0;

   function automatic list_status_type apply_list_op(op_type kind, logic [VAL_W-1:0] value);
      list_status_type         rsp;
      logic signed [VAL_W-1:0] sv;
      int                      pos;
      sv = value;
      pos = 0;
      rsp.status = STATUS_DONE;
      if (kind == OP_INSERT) begin
         if (stored_values.size() >= DEPTH) begin
            rsp.status = STATUS_FULL;
         end else begin
            while (pos < stored_values.size() && stored_values[pos] < sv) pos++;
            stored_values.insert(pos, sv);
         end
      end else begin
         while (pos < stored_values.size() && stored_values[pos] != sv) pos++;
         if (pos >= stored_values.size())
            rsp.status = STATUS_NOT_FOUND;
         else
            stored_values.delete(pos);
      end
      rsp.occupancy  = OCC_W'(stored_values.size());
      rsp.head_valid = (stored_values.size() > 0);
      rsp.head_value = rsp.head_valid ? stored_values[0] : '0;
      return rsp;
   endfunction

   function automatic list_request_type random_request(int n);
      list_request_type r;
      int               phase;
      int               pick;
      logic [VAL_W-1:0] extremes[4];
      extremes = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000, 32'hffff_ffff};
      phase = (n / 60) % 3;
      r.typed = 1'b0;
      case (phase)
         0: r.kind = ($urandom_range(0, 3) != 0) ? OP_INSERT : OP_DELETE;
         1: r.kind = ($urandom_range(0, 3) != 0) ? OP_DELETE : OP_INSERT;
         default: r.kind = $urandom_range(0, 1) ? OP_DELETE : OP_INSERT;
      endcase
      pick = $urandom_range(0, 9);
      if (pick <= 3)
         r.value = $urandom;
      else if (pick <= 5)
         r.value = int'($urandom_range(0, 4)) - 2;
      else if (pick <= 8 && stored_values.size() > 0)
         r.value = stored_values[$urandom_range(0, stored_values.size() - 1)];
      else if (pick <= 8)
         r.value = $urandom;
      else
         r.value = extremes[$urandom_range(0, 3)];
      return r;
   endfunction

   task automatic wait_drained();
      while (expected_status.size() != 0) @(negedge clock);
   endtask

   task automatic send_request(input list_request_type r);
      list_status_type predicted;
      if (req_idle_on && $urandom_range(0, 3) == 0) begin
         req_chan.valid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(negedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.req_type <= r.kind;
      req_chan.value    <= r.value;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predicted = apply_list_op(r.kind, r.value);
      if (r.typed) begin
         predicted.status     = r.status;
         predicted.occupancy  = r.occupancy;
         predicted.head_value = r.head_value;
         predicted.head_valid = r.head_valid;
      end
      expected_status.push_back(predicted);
      accepted_total++;
      @(negedge clock);
   endtask

   initial begin : request_side
      list_request_type r;
      req_chan.valid    = 1'b0;
      req_chan.req_type = OP_INSERT;
      req_chan.value    = '0;
      // delete on empty, extremes, duplicates, removal of the last entry
      directed_requests.push_back('{OP_DELETE, 32'h0000_0000, 1'b1, STATUS_NOT_FOUND,
                                    5'd0, 32'h0000_0000, 1'b0});
      directed_requests.push_back('{OP_INSERT, 32'h8000_0000, 1'b1, STATUS_DONE,
                                    5'd1, 32'h8000_0000, 1'b1});
      directed_requests.push_back('{OP_INSERT, 32'h7fff_ffff, 1'b1, STATUS_DONE,
                                    5'd2, 32'h8000_0000, 1'b1});
      directed_requests.push_back('{OP_INSERT, 32'h7fff_ffff, 1'b1, STATUS_DONE,
                                    5'd3, 32'h8000_0000, 1'b1});
      directed_requests.push_back('{OP_DELETE, 32'h0000_0000, 1'b1, STATUS_NOT_FOUND,
                                    5'd3, 32'h8000_0000, 1'b1});
      directed_requests.push_back('{OP_DELETE, 32'h8000_0000, 1'b1, STATUS_DONE,
                                    5'd2, 32'h7fff_ffff, 1'b1});
      directed_requests.push_back('{OP_DELETE, 32'h7fff_ffff, 1'b1, STATUS_DONE,
                                    5'd1, 32'h7fff_ffff, 1'b1});
      directed_requests.push_back('{OP_DELETE, 32'h7fff_ffff, 1'b1, STATUS_DONE,
                                    5'd0, 32'h0000_0000, 1'b0});
      // fill to capacity, with duplicates and front inserts
      directed_requests.push_back('{OP_INSERT, 32'd5, 1'b0, STATUS_DONE, 5'd0, 32'd0, 1'b0});
      directed_requests.push_back('{OP_INSERT, -32'sd3, 1'b0, STATUS_DONE, 5'd0, 32'd0, 1'b0});
      directed_requests.push_back('{OP_INSERT, 32'd5, 1'b0, STATUS_DONE, 5'd0, 32'd0, 1'b0});
      directed_requests.push_back('{OP_INSERT, 32'd0, 1'b0, STATUS_DONE, 5'd0, 32'd0, 1'b0});
      directed_requests.push_back('{OP_INSERT, 32'hffff_ffff, 1'b0, STATUS_DONE,
                                    5'd0, 32'd0, 1'b0});
      directed_requests.push_back('{OP_INSERT, 32'd12, 1'b0, STATUS_DONE, 5'd0, 32'd0, 1'b0});
      directed_requests.push_back('{OP_INSERT, -32'sd3, 1'b0, STATUS_DONE, 5'd0, 32'd0, 1'b0});
      directed_requests.push_back('{OP_INSERT, 32'd7, 1'b0, STATUS_DONE, 5'd0, 32'd0, 1'b0});
      directed_requests.push_back('{OP_INSERT, 32'd1, 1'b0, STATUS_DONE, 5'd0, 32'd0, 1'b0});
      directed_requests.push_back('{OP_INSERT, 32'd5, 1'b0, STATUS_DONE, 5'd0, 32'd0, 1'b0});
      directed_requests.push_back('{OP_INSERT, 32'd100, 1'b0, STATUS_DONE, 5'd0, 32'd0, 1'b0});
      directed_requests.push_back('{OP_INSERT, -32'sd100, 1'b0, STATUS_DONE, 5'd0, 32'd0, 1'b0});
      directed_requests.push_back('{OP_INSERT, 32'haaaa_aaaa, 1'b0, STATUS_DONE,
                                    5'd0, 32'd0, 1'b0});
      directed_requests.push_back('{OP_INSERT, 32'h5555_5555, 1'b0, STATUS_DONE,
                                    5'd0, 32'd0, 1'b0});
      directed_requests.push_back('{OP_INSERT, 32'd2, 1'b0, STATUS_DONE, 5'd0, 32'd0, 1'b0});
      directed_requests.push_back('{OP_INSERT, 32'd3, 1'b0, STATUS_DONE, 5'd0, 32'd0, 1'b0});
      directed_requests.push_back('{OP_INSERT, 32'd0, 1'b1, STATUS_FULL,
                                    5'd16, 32'haaaa_aaaa, 1'b1});
      directed_requests.push_back('{OP_DELETE, 32'd5, 1'b0, STATUS_DONE, 5'd0, 32'd0, 1'b0});

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_requests[i]) send_request(directed_requests[i]);

      for (int n = 0; n < 2000; n++) begin
         quiet_tail  = (n >= 1700);
         req_idle_on = !quiet_tail && ((n / 150) % 3 != 1);
         if (n == 1000) begin
            req_chan.valid <= 1'b0;
            wait_drained();
         end
         r = random_request(n);
         send_request(r);
      end
      req_chan.valid <= 1'b0;

      wait_drained();
      repeat (5) @(posedge clock);
      if (mismatches == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   initial begin : response_side
      rsp_chan.ready = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (!long_hold_done && accepted_total >= 400) begin
            // hold off long enough for the store to back up into the requests
            rsp_chan.ready <= 1'b0;
            repeat (120) @(negedge clock);
            long_hold_done = 1'b1;
         end else if (quiet_tail || ((accepted_total / 250) % 3 == 2) ||
                      $urandom_range(0, 3) != 0) begin
            rsp_chan.ready <= 1'b1;
         end else begin
            rsp_chan.ready <= 1'b0;
            repeat ($urandom_range(1, 8) - 1) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      list_status_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (expected_status.size() == 0) begin
            mismatches++;
            $display("%0t: response with no request pending: status %0d occ %0d head %h/%0b",
                     $time, rsp_chan.status, rsp_chan.occupancy, rsp_chan.head_value,
                     rsp_chan.head_valid);
         end else begin
            want = expected_status.pop_front();
            if (rsp_chan.status !== want.status) begin
               mismatches++;
               $display("%0t: status expected %0d actual %0d",
                        $time, want.status, rsp_chan.status);
            end
            if (rsp_chan.occupancy !== want.occupancy) begin
               mismatches++;
               $display("%0t: occupancy expected %0d actual %0d",
                        $time, want.occupancy, rsp_chan.occupancy);
            end
            if (rsp_chan.head_value !== want.head_value) begin
               mismatches++;
               $display("%0t: head_value expected %h actual %h",
                        $time, want.head_value, rsp_chan.head_value);
            end
            if (rsp_chan.head_valid !== want.head_valid) begin
               mismatches++;
               $display("%0t: head_valid expected %0b actual %0b",
                        $time, want.head_valid, rsp_chan.head_valid);
            end
         end
      end
   end

   initial begin : watchdog
      #3_000_000;
      $display("Some tests failed");
      $finish;
   end

endmodule

@@ sorted_list_insert_delete.f @@
hdl/sli_pkg.sv
hdl/sli_req_if.sv
hdl/sli_rsp_if.sv
hdl/sli_cell.sv
hdl/sorted_list_insert_delete.sv
hdl/sli_checker.sv
dv/sorted_list_insert_delete_tb.sv
